FILE: src/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT,
      ST_READ,
      ST_RESP
   } state_type;

   // one result as it leaves the sequencer
   typedef struct packed {
      logic [COUNT_W-1:0] item_count;
      logic [1:0]         status;
      logic [VALUE_W-1:0] read_value;
   } res_type;

endpackage

FILE: src/pls_mem.sv
`timescale 1ns / 1ps

module pls_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pls_ctrl.sv
`timescale 1ns / 1ps

module pls_ctrl #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic [4:0]             req_position,
   input  logic [31:0]            req_value,
   output logic                   res_valid,
   input  logic                   res_ready,
   output pls_pkg::res_type       res
);
   import pls_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   length_ff, length_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]   last_ptr_ff, last_ptr_in;
   logic [IDX_W-1:0]   wr_addr_ff, wr_addr_in;
   logic               rd_more_ff, rd_more_in;
   logic               rd_act_ff, rd_act_in;
   logic               ins_ff, ins_in;
   logic [IDX_W-1:0]   put_addr_ff, put_addr_in;
   logic [VALUE_W-1:0] put_val_ff, put_val_in;
   res_type            res_ff, res_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [VALUE_W-1:0] mem_rdata;

   logic [CMP_W-1:0]   pos_c, len_c, cap_c;
   logic [CNT_W-1:0]   len_inc, len_dec;

   assign pos_c   = CMP_W'(req_position);
   assign len_c   = CMP_W'(length_ff);
   assign cap_c   = CMP_W'(CAPACITY);
   assign len_inc = length_ff + CNT_W'(1);
   assign len_dec = length_ff - CNT_W'(1);

   pls_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .DATA_W (VALUE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= '0;
         rd_act_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         length_ff <= length_in;
         rd_act_ff <= rd_act_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      last_ptr_ff <= last_ptr_in;
      wr_addr_ff  <= wr_addr_in;
      rd_more_ff  <= rd_more_in;
      ins_ff      <= ins_in;
      put_addr_ff <= put_addr_in;
      put_val_ff  <= put_val_in;
      res_ff      <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      length_in   = length_ff;
      rd_ptr_in   = rd_ptr_ff;
      last_ptr_in = last_ptr_ff;
      wr_addr_in  = wr_addr_ff;
      rd_more_in  = rd_more_ff;
      rd_act_in   = 1'b0;
      ins_in      = ins_ff;
      put_addr_in = put_addr_ff;
      put_val_in  = put_val_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_addr_ff;
      mem_wdata   = mem_rdata;
      mem_re      = 1'b0;
      mem_raddr   = rd_ptr_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               res_in.read_value = '0;
               res_in.status     = STAT_RANGE;
               res_in.item_count = COUNT_W'(length_ff);
               put_addr_in       = IDX_W'(pos_c);
               put_val_in        = req_value;
               state_in          = ST_RESP;
               case (req_operation)
                  OP_INSERT: begin
                     if (pos_c > len_c) begin
                        res_in.status = STAT_RANGE;
                     end else if (len_c >= cap_c) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        res_in.status     = STAT_DONE;
                        res_in.item_count = COUNT_W'(len_inc);
                        length_in         = len_inc;
                        if (pos_c == len_c) begin
                           state_in = ST_PUT;
                        end else begin
                           // move the tail up, top entry first
                           rd_ptr_in   = IDX_W'(len_dec);
                           last_ptr_in = IDX_W'(pos_c);
                           rd_more_in  = 1'b1;
                           ins_in      = 1'b1;
                           state_in    = ST_SHIFT;
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (pos_c < len_c) begin
                        res_in.status     = STAT_DONE;
                        res_in.item_count = COUNT_W'(len_dec);
                        length_in         = len_dec;
                        if (pos_c + CMP_W'(1) != len_c) begin
                           // move the tail down, lowest entry first
                           rd_ptr_in   = IDX_W'(pos_c + CMP_W'(1));
                           last_ptr_in = IDX_W'(len_dec);
                           rd_more_in  = 1'b1;
                           ins_in      = 1'b0;
                           state_in    = ST_SHIFT;
                        end
                     end
                  end
                  OP_READ: begin
                     if (pos_c < len_c) begin
                        res_in.status = STAT_DONE;
                        mem_re        = 1'b1;
                        mem_raddr     = IDX_W'(pos_c);
                        state_in      = ST_READ;
                     end
                  end
                  default: begin
                     res_in.status = STAT_RANGE;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // read one entry ahead, write the one fetched last cycle
            if (rd_more_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_ptr_ff;
               rd_act_in  = 1'b1;
               wr_addr_in = ins_ff ? rd_ptr_ff + IDX_W'(1) : rd_ptr_ff - IDX_W'(1);
               if (rd_ptr_ff == last_ptr_ff) begin
                  rd_more_in = 1'b0;
               end else begin
                  rd_ptr_in = ins_ff ? rd_ptr_ff - IDX_W'(1) : rd_ptr_ff + IDX_W'(1);
               end
            end
            if (rd_act_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = mem_rdata;
               if (!rd_more_ff) begin
                  state_in = ins_ff ? ST_PUT : ST_RESP;
               end
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = put_addr_ff;
            mem_wdata = put_val_ff;
            state_in  = ST_RESP;
         end
         ST_READ: begin
            res_in.read_value = mem_rdata;
            state_in          = ST_RESP;
         end
         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

FILE: src/positional_list_store.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a simple
// dual-port synchronous RAM with a length counter. Requests insert at, delete at or
// read a position; each gives one result with the read value, a status and
// the count after the request. One request is handled at a time. An insert
// moves the entries at and above its position up one place, top entry first,
// then writes the new value; a delete moves the entries above its position
// down one place. The RAM moves one entry per cycle while the tail is
// shifted. The result register lets the next request be taken while a result
// still waits on rsp_tready.

module positional_list_store #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], position[6:2], value[38:7], zero fill [39]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[31:0], status[33:32], item_count[38:34], zero fill [39]
   output logic [39:0] rsp_tdata
);
   import pls_pkg::*;

   logic    res_valid;
   logic    res_ready;
   res_type res;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_data_ff, rsp_data_in;

   pls_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_operation (req_tdata[1:0]),
      .req_position  (req_tdata[6:2]),
      .req_value     (req_tdata[38:7]),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

FILE: src/pls_checker.sv
`timescale 1ns / 1ps

module pls_checker #(
   parameter int CAPACITY = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import pls_pkg::*;

   // one request in flight: no transfer on the cycle after one
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("unknown status code");

   // a rejected request never returns data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] != STAT_DONE |-> rsp_tdata[31:0] == 32'd0)
      else $error("rejected request returned a value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp_tdata[38:34]) <= CAPACITY)
      else $error("count above capacity");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/positional_list_store_tb.sv
`timescale 1ns / 1ps

module positional_list_store_tb;
   import pls_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 700;
   localparam int IDLE_LIMIT   = 5000;
   localparam int PRESSURE_AT  = 300;
   localparam int PRESSURE_LEN = 400;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } request_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;

   positional_list_store #(
      .CAPACITY(LIST_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   request_type pending_q[$];
   res_type     expected_q[$];

   // predicted list contents
   logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
   int                 list_len = 0;

   // length as the stimulus generator sees it, used to aim positions
   int gen_len = 0;

   int  errors       = 0;
   int  sent_count   = 0;
   int  results_seen = 0;
   bit  offering     = 1'b0;
   bit  pressure_done = 1'b0;

   function automatic res_type apply_request(request_type r);
      res_type res;
      int      p;
      res.read_value = '0;
      res.status     = STAT_DONE;
      p = int'(r.pos);
      case (r.op)
         OP_INSERT: begin
            if (p > list_len) begin
               res.status = STAT_RANGE;
            end else if (list_len >= LIST_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
               list_mem[p] = r.value;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (p >= list_len) begin
               res.status = STAT_RANGE;
            end else begin
               for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         OP_READ: begin
            if (p >= list_len) res.status = STAT_RANGE;
            else res.read_value = list_mem[p];
         end
         default: res.status = STAT_RANGE;
      endcase
      res.item_count = COUNT_W'(list_len);
      return res;
   endfunction

   task automatic add_request(logic [1:0] op, int pos, logic [VALUE_W-1:0] value);
      request_type r;
      r.op    = op;
      r.pos   = POS_W'(pos);
      r.value = value;
      pending_q.push_back(r);
      if (op == OP_INSERT && pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      else if (op == OP_DELETE && pos < gen_len) gen_len--;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      int k;
      k = $urandom_range(99, 0);
      if (k < 3) return 32'h8000_0000;
      if (k < 6) return 32'h7FFF_FFFF;
      if (k < 8) return 32'hFFFF_FFFF;
      if (k < 10) return 32'h0000_0000;
      return $urandom;
   endfunction

   // driver: one item offered at a time, random gaps between transfers
   always @(posedge clock) begin : drive
      request_type cur;
      int          gap_left;
      bit          calm;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         offering = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(apply_request(cur));
            sent_count++;
            offering = 1'b0;
            calm = ((sent_count / 64) % 4) == 3;
            if (calm || $urandom_range(99, 0) < 65) gap_left = 0;
            else if ($urandom_range(99, 0) < 85) gap_left = $urandom_range(3, 1);
            else gap_left = $urandom_range(40, 8);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() != 0) begin
               cur = pending_q.pop_front();
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata  <= {1'b0, cur.value, cur.pos, cur.op};
      end
   end

   // monitor: checks each result transfer and applies back-pressure
   always @(posedge clock) begin : sink
      res_type got_res;
      res_type want;
      int      hold_left;
      bit      calm;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_res = rsp_tdata[38:0];
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               if (got_res.read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value expected %h actual %h",
                           $time, want.read_value, got_res.read_value);
               end
               if (got_res.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got_res.status);
               end
               if (got_res.item_count !== want.item_count) begin
                  errors++;
                  $display("%0t: item_count expected %0d actual %0d",
                           $time, want.item_count, got_res.item_count);
               end
            end
            results_seen++;
            // long hold-off while the driver keeps offering, to fill the block
            if (results_seen == PRESSURE_AT && !pressure_done) begin
               hold_left = PRESSURE_LEN;
               pressure_done = 1'b1;
            end
         end
         calm = ((results_seen / 64) % 4) == 3;
         if (hold_left == 0 && !calm && $urandom_range(99, 0) < 12) begin
            if ($urandom_range(9, 0) < 8) hold_left = $urandom_range(3, 1);
            else hold_left = $urandom_range(30, 8);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int r;
      int ins_bias;
      logic [1:0] op;
      int pos;

      // directed: empty list, bad positions, unused code, extremes, full store
      add_request(OP_READ,   0,  32'h1234_5678);
      add_request(OP_DELETE, 0,  32'hFFFF_FFFF);
      add_request(OP_INSERT, 1,  32'h5555_5555);
      add_request(OP_UNUSED, 31, 32'hFFFF_FFFF);
      add_request(OP_INSERT, 0,  32'h8000_0000);
      add_request(OP_INSERT, 1,  32'h7FFF_FFFF);
      add_request(OP_INSERT, 0,  32'h0000_0000);
      add_request(OP_READ,   0,  32'h0);
      add_request(OP_READ,   2,  32'h0);
      add_request(OP_READ,   31, 32'h0);
      add_request(OP_DELETE, 1,  32'h0);
      while (gen_len < LIST_DEPTH) add_request(OP_INSERT, gen_len / 2, $urandom);
      add_request(OP_INSERT, 8,  32'hAAAA_AAAA);
      add_request(OP_INSERT, 31, 32'hAAAA_AAAA);
      add_request(OP_READ,   15, 32'h0);
      add_request(OP_DELETE, 15, 32'h0);
      add_request(OP_DELETE, 0,  32'h0);

      // random: phases lean towards filling or draining the list
      ins_bias = 60;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(3, 0))
               0: ins_bias = 80;
               1: ins_bias = 60;
               2: ins_bias = 45;
               default: ins_bias = 25;
            endcase
         end
         r = $urandom_range(99, 0);
         if (r < 3) op = OP_UNUSED;
         else if (r < ins_bias) op = OP_INSERT;
         else if (r < ins_bias + (100 - ins_bias) / 2) op = OP_DELETE;
         else op = OP_READ;
         if ($urandom_range(99, 0) < 85) begin
            if (op == OP_INSERT) pos = $urandom_range(gen_len, 0);
            else pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1, 0);
         end else begin
            pos = $urandom_range(31, 0);
         end
         add_request(op, pos, pick_value());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || offering || expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/pls_pkg.sv
src/pls_mem.sv
src/pls_ctrl.sv
src/positional_list_store.sv
src/pls_checker.sv
sim/positional_list_store_tb.sv
